>>> rtl/core/itdt_pkg.sv
// Package for the integer to decimal text converter.
// Shared constants and the glyph function; no dependencies.
package itdt_pkg;
  localparam int unsigned CharBits = 7;
  localparam logic [CharBits-1:0] AsciiZero  = 7'h30;
  localparam logic [CharBits-1:0] AsciiMinus = 7'h2D;
  localparam logic [CharBits-1:0] AsciiAlpha = 7'h37; // 'A' - 10

  function automatic logic [CharBits-1:0] glyph(input logic [3:0] d);
    if (d < 4'd10) return AsciiZero + CharBits'(d);
    return AsciiAlpha + CharBits'(d);
  endfunction
endpackage

>>> rtl/core/itdt_if.sv
// Valid/ready channel interfaces for the converter.
// Depends on itdt_pkg.
interface itdt_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] value_bits;
  logic        is_signed;
  logic        use_hex;
  modport source (output valid, value_bits, is_signed, use_hex, input ready);
  modport sink   (input valid, value_bits, is_signed, use_hex, output ready);
endinterface

interface itdt_out_if;
  import itdt_pkg::*;
  logic                valid;
  logic                ready;
  logic [CharBits-1:0] character;
  logic                last_char;
  modport source (output valid, character, last_char, input ready);
  modport sink   (input valid, character, last_char, output ready);
endinterface

>>> rtl/core/itdt_dd_stage.sv
// One pipeline stage of the shift-and-add-3 BCD converter: BITS_PER_STAGE bits.
// Depends on itdt_pkg.
module itdt_dd_stage import itdt_pkg::*; #(
  parameter int VALUE_BITS     = 64,
  parameter int NDIG           = 20,
  parameter int BITS_PER_STAGE = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_vld,
  input  logic [VALUE_BITS-1:0] in_bin,
  input  logic [4*NDIG-1:0]     in_bcd,
  input  logic [1:0]            in_flags,
  output logic                  out_vld,
  output logic [VALUE_BITS-1:0] out_bin,
  output logic [4*NDIG-1:0]     out_bcd,
  output logic [1:0]            out_flags
);
  logic [VALUE_BITS-1:0] bin_n;
  logic [4*NDIG-1:0]     bcd_n;

  // flags[1]=hex: pure shift, no digit correction
  always_comb begin
    bin_n = in_bin;
    bcd_n = in_bcd;
    for (int s = 0; s < BITS_PER_STAGE; s++) begin
      if (!in_flags[1]) begin
        for (int d = 0; d < NDIG; d++) begin
          if (bcd_n[4*d +: 4] > 4'd4) bcd_n[4*d +: 4] = bcd_n[4*d +: 4] + 4'd3;
        end
      end
      bcd_n = {bcd_n[4*NDIG-2:0], bin_n[VALUE_BITS-1]};
      bin_n = {bin_n[VALUE_BITS-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_vld <= 1'b0;
    else if (adv) out_vld <= in_vld;
    if (adv) begin
      out_bin   <= bin_n;
      out_bcd   <= bcd_n;
      out_flags <= in_flags;
    end
  end
endmodule

>>> rtl/core/integer_to_decimal_text_top.sv
// Integer to ASCII text converter. Each input transfer carries one integer and two
// flags; the block answers with its decimal (optionally signed) or uppercase hex text,
// most significant character first, last_char on the final one, no leading zeros.
// Conversion is a front register (mask, sign, magnitude) followed by a shift-and-add-3
// pipeline of (VALUE_BITS+7)/8 stages (8 bits per stage, hex skips the correction).
// A new item can enter every cycle while the emitter is idle.
// The character emitter then sends one character per cycle while out_ch.ready is
// high; an item has 1 to MAX_DIGITS characters at the output, which sets the
// sustained rate. The first output transfer follows the front register, the stage
// registers and the emitter load. The whole pipe, input included, stalls while the
// emitter is busy with an earlier item, so nothing is lost or repeated.
// Depends on itdt_pkg, itdt_if, itdt_dd_stage.
module integer_to_decimal_text_top import itdt_pkg::*; #(
  parameter int VALUE_BITS = 64,
  parameter int MAX_DIGITS = 20
) (
  input logic       clk,
  input logic       rst,
  itdt_in_if.sink   in_ch,
  itdt_out_if.source out_ch
);
  localparam int NDIG   = 20;  // decimal digits for up to 64 bits; also covers hex
  localparam int BPS    = 8;
  localparam int NSTG   = (VALUE_BITS + BPS - 1) / BPS;
  localparam int PADW   = NSTG * BPS;
  localparam int TXT    = NDIG + 1;  // digits plus sign
  localparam int IDXW   = $clog2(TXT + 1);

  // --- pipeline control: whole pipe advances when the emitter can take its tail
  logic adv;
  logic emit_busy;
  logic load;

  // --- front stage: mask, sign, magnitude
  logic              v0;
  logic [PADW-1:0]   b0;
  logic [1:0]        f0;     // {hex, neg}
  logic [VALUE_BITS-1:0] raw, mag;
  logic              neg_in;

  assign raw    = in_ch.value_bits[VALUE_BITS-1:0];
  assign neg_in = !in_ch.use_hex && in_ch.is_signed && raw[VALUE_BITS-1];
  assign mag    = neg_in ? (~raw + 1'b1) : raw;
  assign in_ch.ready = adv;

  // magnitude sits at the bottom: padding bits shift in first as leading zeros
  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (adv) v0 <= in_ch.valid;
    if (adv) begin
      b0 <= PADW'(mag);
      f0 <= {in_ch.use_hex, neg_in};
    end
  end

  // --- conversion stages
  logic            sv  [NSTG+1];
  logic [PADW-1:0] sb  [NSTG+1];
  logic [4*NDIG-1:0] sd [NSTG+1];
  logic [1:0]      sf  [NSTG+1];

  assign sv[0] = v0;
  assign sb[0] = b0;
  assign sd[0] = '0;
  assign sf[0] = f0;

  for (genvar g = 0; g < NSTG; g++) begin : g_stg
    itdt_dd_stage #(.VALUE_BITS(PADW), .NDIG(NDIG), .BITS_PER_STAGE(BPS)) u_stg (
      .clk, .rst, .adv,
      .in_vld(sv[g]), .in_bin(sb[g]), .in_bcd(sd[g]), .in_flags(sf[g]),
      .out_vld(sv[g+1]), .out_bin(sb[g+1]), .out_bcd(sd[g+1]), .out_flags(sf[g+1])
    );
  end

  // --- emitter: text buffer, start index and end index
  logic [CharBits-1:0] txt [TXT];
  logic [IDXW-1:0]     pos, stop;
  logic [CharBits-1:0] txt_n [TXT];
  logic [IDXW-1:0]     first_n, start_n;
  logic                done_tx;

  assign load    = adv && sv[NSTG];
  assign adv     = !emit_busy || done_tx;
  assign done_tx = emit_busy && out_ch.ready && (pos == stop - 1'b1);

  // Text slot NDIG-1-d holds digit d; slot index NDIG holds a minus glyph and is never emitted.
  always_comb begin
    logic found;
    found   = 1'b0;
    first_n = IDXW'(NDIG - 1);
    for (int i = 0; i < NDIG; i++) begin
      txt_n[i] = glyph(sd[NSTG][4*(NDIG-1-i) +: 4]);
      if (!found && sd[NSTG][4*(NDIG-1-i) +: 4] != 4'd0) begin
        found   = 1'b1;
        first_n = IDXW'(i);
      end
    end
    txt_n[NDIG] = AsciiMinus;
    start_n = first_n;
    // minus goes one slot ahead of the first digit
    if (sf[NSTG][0]) begin
      start_n = first_n - 1'b1;
    end
    if (IDXW'(NDIG) - start_n > IDXW'(MAX_DIGITS)) start_n = IDXW'(NDIG - MAX_DIGITS);
  end

  logic neg_r;
  logic [IDXW-1:0] minus_at;

  always_ff @(posedge clk) begin
    if (rst) emit_busy <= 1'b0;
    else if (load) emit_busy <= 1'b1;
    else if (done_tx) emit_busy <= 1'b0;
    if (load) begin
      for (int i = 0; i < TXT; i++) txt[i] <= txt_n[i];
      pos      <= start_n;
      stop     <= IDXW'(NDIG);
      neg_r    <= sf[NSTG][0] && (first_n != '0) &&
                  (IDXW'(NDIG) - first_n < IDXW'(MAX_DIGITS));
      minus_at <= first_n - 1'b1;
    end else if (emit_busy && out_ch.ready) begin
      pos <= pos + 1'b1;
    end
  end

  assign out_ch.valid     = emit_busy;
  assign out_ch.character = (neg_r && pos == minus_at) ? AsciiMinus
                           : txt[pos[IDXW-1:0] < IDXW'(TXT) ? pos : '0];
  assign out_ch.last_char = (pos == stop - 1'b1);
endmodule

>>> rtl/core/itdt_checker.sv
// Port-level checker for integer_to_decimal_text_top, bound to the top level.
// Depends on itdt_pkg.
module itdt_checker import itdt_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input logic [CharBits-1:0] out_char,
  input logic                out_last
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
    else $error("stalled output changed");
  a_minus_first: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_char == AsciiMinus |-> !out_last)
    else $error("minus sign ends text");
  a_minus_lead: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_last |=> !(out_valid && out_char == AsciiMinus))
    else $error("minus sign inside text");
endmodule

bind integer_to_decimal_text_top itdt_checker u_itdt_checker (
  .clk, .rst,
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .out_char(out_ch.character), .out_last(out_ch.last_char)
);

>>> tb/sv/itdt_tb_if.sv
// Note: the channel interfaces come from rtl/core/itdt_if.sv.
// This file holds the scoreboard class and its character type used by the testbench top.
// Depends on itdt_pkg.
package itdt_tb_pkg;
  import itdt_pkg::*;

  typedef struct packed {
    logic [CharBits-1:0] character;
    logic                last_char;
  } text_char_t;

  class text_scoreboard;
    text_char_t pending_chars[$];
    int         error_count;

    function new();
      error_count = 0;
    endfunction

    // Render one accepted number as text and queue its characters.
    function void note_number(logic [63:0] value_bits, logic is_signed, logic use_hex);
      logic [63:0] mag;
      logic [CharBits-1:0] rev[$];
      logic negative;
      logic [3:0] d;
      text_char_t c;
      mag = value_bits;
      negative = !use_hex && is_signed && value_bits[63];
      if (negative) mag = ~value_bits + 64'd1;
      do begin
        d = use_hex ? mag[3:0] : 4'(mag % 64'd10);
        rev.push_back(d < 4'd10 ? AsciiZero + CharBits'(d) : AsciiAlpha + CharBits'(d));
        mag = use_hex ? mag >> 4 : mag / 64'd10;
      end while (mag != 0);
      if (negative) rev.push_back(AsciiMinus);
      for (int k = rev.size() - 1; k >= 0; k--) begin
        c.character = rev[k];
        c.last_char = (k == 0);
        pending_chars.push_back(c);
      end
    endfunction

    function void check_char(logic [CharBits-1:0] character, logic last_char, longint t);
      text_char_t e;
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected char %h last %b", t, character, last_char);
        error_count++;
        return;
      end
      e = pending_chars.pop_front();
      if (e.character !== character || e.last_char !== last_char) begin
        $display("%0t: mismatch expected %h/%b actual %h/%b",
                 t, e.character, e.last_char, character, last_char);
        error_count++;
      end
    endfunction
  endclass
endpackage

>>> tb/sv/integer_to_decimal_text_top_tb.sv
// Testbench for integer_to_decimal_text_top: directed and random numbers,
// random idling on both channels, scoreboard check of every character.
// Depends on itdt_pkg, itdt_if, itdt_tb_pkg and the RTL top.
module integer_to_decimal_text_top_tb;
  import itdt_pkg::*;
  import itdt_tb_pkg::*;

  logic clk;
  logic rst;
  itdt_in_if  in_ch();
  itdt_out_if out_ch();

  integer_to_decimal_text_top DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  text_scoreboard score;
  longint cycle_count;
  bit     stim_done;
  bit     hold_output;    // long receiver stall requested by the sender side

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Timeout guard: reports FAIL and stops once the cycle counter passes its limit.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("FAIL integer_to_decimal_text_top");
        $finish;
      end
    end
  end

  // Receiver: random idle per transfer, plus a long hold-off on request.
  initial begin
    int wait_cycles;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_output) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_output = 1'b0;
      end
      wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (wait_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      // transfer happened at this edge
    end
  end

  // Output monitor: checks every transfer.
  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      score.check_char(out_ch.character, out_ch.last_char, $time);
  end

  // Offer one number; valid stays high across back-to-back transfers.
  task automatic send_number(logic [63:0] v, logic s, logic h, bit no_gap);
    int gap;
    gap = no_gap ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9));
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.value_bits <= v;
    in_ch.is_signed  <= s;
    in_ch.use_hex    <= h;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    score.note_number(v, s, h);
  endtask

  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    int nbits;
    v = {$urandom(), $urandom()};
    // spread magnitudes so short and long texts both show up
    nbits = $urandom_range(1, 64);
    case ($urandom_range(0, 3))
      0: v = v >> (64 - nbits);
      1: v = ~(v >> (64 - nbits)); // small negatives
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    logic [63:0] corner[$];
    score = new();
    stim_done = 1'b0;
    hold_output = 1'b0;
    rst <= 1'b1;
    in_ch.valid      <= 1'b0;
    in_ch.value_bits <= '0;
    in_ch.is_signed  <= 1'b0;
    in_ch.use_hex    <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero, ones, most negative, max positive, values around powers of ten.
    corner = '{64'd0, 64'd1, 64'd9, 64'd10, 64'hFFFF_FFFF_FFFF_FFFF,
               64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
               64'd9999999999999999999, 64'd10000000000000000000,
               64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210};
    foreach (corner[i])
      for (int m = 0; m < 4; m++)
        if (i < 5 || m != 3) send_number(corner[i], m[0], m[1], 1'b0);

    // Burst against a stalled receiver so the pipe fills and blocks input.
    hold_output = 1'b1;
    for (int i = 0; i < 30; i++)
      send_number(rand_value(), $urandom_range(0, 1), $urandom_range(0, 1), 1'b1);

    for (int i = 0; i < 260; i++) begin
      if (i == 150) begin
        // Sender pause until the block has drained.
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (score.pending_chars.size() != 0) @(posedge clk);
      end
      send_number(rand_value(), $urandom_range(0, 1), $urandom_range(0, 1),
                  (i % 40) < 10);
    end
    in_ch.valid <= 1'b0;
    stim_done = 1'b1;

    while (score.pending_chars.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (score.error_count == 0)
      $display("PASS integer_to_decimal_text_top");
    else
      $display("FAIL integer_to_decimal_text_top");
    $finish;
  end
endmodule
